>>> rtl/b21d_pkg.sv
// ----------------------------------------------------------------------------
// b21d_pkg
// Shared widths, constants and helpers of the binary to base-21 digit core.
// ----------------------------------------------------------------------------
package b21d_pkg;

	// Field widths
	localparam int VAL_W  = 31;
	localparam int CHAR_W = 7;
	localparam int DIG_W  = 5;

	// Digit count: a 31-bit value has at most eight base-21 digits
	localparam int MAX_DIGITS = 8;
	localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
	localparam int IDX_W      = $clog2(MAX_DIGITS);

	// Divide by 21 as (v * RECIP) >> SHIFT, exact for every v below 2^31
	localparam logic [DIG_W-1:0] RADIX = 5'd21;
	localparam int               SHIFT = 35;
	localparam logic [VAL_W-1:0] RECIP = 31'd1636178018;
	localparam int               QUO_W = 27;
	localparam int               PROD_W = 2 * VAL_W;

	// ASCII anchors
	localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'd48;
	localparam logic [CHAR_W-1:0] CHAR_A    = 7'd65;
	localparam logic [DIG_W-1:0]  TEN       = 5'd10;

	typedef logic [MAX_DIGITS-1:0][DIG_W-1:0] digits_t;

	// Digit value 0..20 to its ASCII glyph
	function automatic logic [CHAR_W-1:0] glyph(input logic [DIG_W-1:0] d);
		logic [DIG_W-1:0] above;
		above = d - TEN;
		if (d < TEN) begin
			return CHAR_ZERO + {{(CHAR_W - DIG_W){1'b0}}, d};
		end
		return CHAR_A + {{(CHAR_W - DIG_W){1'b0}}, above};
	endfunction

endpackage

>>> rtl/b21d_if.sv
// ----------------------------------------------------------------------------
// b21d_if
// Valid/ready channels of the base-21 core: input number and output digit.
// ----------------------------------------------------------------------------
interface b21d_value_if;
	logic                        valid;
	logic                        ready;
	logic [b21d_pkg::VAL_W-1:0]  value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface b21d_digit_if;
	logic                        valid;
	logic                        ready;
	logic [b21d_pkg::CHAR_W-1:0] digit_char;
	logic                        last;

	modport source (output valid, output digit_char, output last, input ready);
	modport sink   (input valid, input digit_char, input last, output ready);
endinterface

>>> rtl/binary_to_base21_digits_core.sv
// An accepted beat passes the eight divide stage registers and then the emitter
// register before its first digit beat. The single digit emitter sends one digit
// beat per cycle while digit.ready is high, a number's 1 to 8 digits in turn.
// The eight divide stages take a new number in every cycle the emitter can load.
// Reset (arst_n low, asynchronous) clears all valid bits; payload is not reset.
// ----------------------------------------------------------------------------
// binary_to_base21_digits_core
// Eight-stage divide-by-21 pipeline, one digit per stage, feeding an emitter
// that sends the digits most significant first as ASCII with a last mark.
// ----------------------------------------------------------------------------
module binary_to_base21_digits_core (
	input  logic          clk,
	input  logic          arst_n,
	b21d_value_if.sink    num,
	b21d_digit_if.source  digit
);

	localparam int N = b21d_pkg::MAX_DIGITS;

	// Pipeline registers, one entry per divide stage
	logic [N-1:0]                      vld_s;
	logic [b21d_pkg::VAL_W-1:0]        val_s  [N];
	b21d_pkg::digits_t                 digs_s [N];
	logic [b21d_pkg::CNT_W-1:0]        cnt_s  [N];

	// Stage inputs and next values
	logic [N-1:0]                      vld_in;
	logic [b21d_pkg::VAL_W-1:0]        val_in  [N];
	b21d_pkg::digits_t                 digs_in [N];
	logic [b21d_pkg::CNT_W-1:0]        cnt_in  [N];
	logic [b21d_pkg::PROD_W-1:0]       prod    [N];
	logic [b21d_pkg::QUO_W-1:0]        quo     [N];
	logic [b21d_pkg::DIG_W-1:0]        q21_lo  [N];
	logic [b21d_pkg::DIG_W-1:0]        rem     [N];
	b21d_pkg::digits_t                 digs_nx [N];
	logic [b21d_pkg::CNT_W-1:0]        cnt_nx  [N];

	// Emitter
	logic                              emit_valid_q;
	b21d_pkg::digits_t                 emit_digs_q;
	logic [b21d_pkg::IDX_W-1:0]        emit_idx_q;
	logic [b21d_pkg::CNT_W-1:0]        last_idx;
	logic                              en;

	// Whole pipeline moves when the emitter is empty or sends its last beat
	assign en        = !emit_valid_q || (digit.ready && (emit_idx_q == '0));
	assign num.ready = en;

	for (genvar k = 0; k < N; k++) begin : g_stage
		// Stage input: the port for the first stage, else the stage before
		if (k == 0) begin : g_first
			assign vld_in[k]  = num.valid;
			assign val_in[k]  = num.value;
			assign digs_in[k] = '0;
			assign cnt_in[k]  = '0;
		end else begin : g_next
			assign vld_in[k]  = vld_s[k-1];
			assign val_in[k]  = val_s[k-1];
			assign digs_in[k] = digs_s[k-1];
			assign cnt_in[k]  = cnt_s[k-1];
		end

		// One divide step: quotient by reciprocal, remainder from the low bits
		always_comb begin
			prod[k]   = {{b21d_pkg::VAL_W{1'b0}}, val_in[k]} *
			            {{b21d_pkg::VAL_W{1'b0}}, b21d_pkg::RECIP};
			quo[k]    = prod[k][b21d_pkg::SHIFT + b21d_pkg::QUO_W - 1 : b21d_pkg::SHIFT];
			// low five bits of quo * 21 = quo*16 + quo*4 + quo
			q21_lo[k] = {quo[k][0], 4'b0000} + {quo[k][2:0], 2'b00} + quo[k][4:0];
			rem[k]    = val_in[k][b21d_pkg::DIG_W-1:0] - q21_lo[k];
			digs_nx[k]    = digs_in[k];
			digs_nx[k][k] = rem[k];
			// first digit always counts; later ones only while the value is nonzero
			if (k == 0 || val_in[k] != '0) begin
				cnt_nx[k] = b21d_pkg::CNT_W'(k + 1);
			end else begin
				cnt_nx[k] = cnt_in[k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				val_s[k]  <= {{(b21d_pkg::VAL_W - b21d_pkg::QUO_W){1'b0}}, quo[k]};
				digs_s[k] <= digs_nx[k];
				cnt_s[k]  <= cnt_nx[k];
			end
		end
	end

	// Emitter valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_valid_q <= 1'b0;
		end else if (en) begin
			emit_valid_q <= vld_s[N-1];
		end
	end

	// Emitter payload: load the digits, then count down to the last one
	assign last_idx = cnt_s[N-1] - b21d_pkg::CNT_W'(1);

	always_ff @(posedge clk) begin
		if (en) begin
			emit_digs_q <= digs_s[N-1];
			emit_idx_q  <= last_idx[b21d_pkg::IDX_W-1:0];
		end else if (digit.valid && digit.ready) begin
			emit_idx_q  <= emit_idx_q - b21d_pkg::IDX_W'(1);
		end
	end

	assign digit.valid      = emit_valid_q;
	assign digit.digit_char = b21d_pkg::glyph(emit_digs_q[emit_idx_q]);
	assign digit.last       = (emit_idx_q == '0);

`ifndef NO_ASSERTIONS
	// A stalled digit beat must hold the whole pipeline
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(digit.valid && !digit.ready) |-> !num.ready)
		else $error("input accepted while a digit beat is stalled");

	// Without advance the stage valid bits hold
	a_hold_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s))
		else $error("pipeline moved during a stall");

	// Every emitted character is a base-21 glyph
	a_glyph_range: assert property (@(posedge clk) disable iff (!arst_n)
		digit.valid |-> ((digit.digit_char >= 7'd48 && digit.digit_char <= 7'd57) ||
		                 (digit.digit_char >= 7'd65 && digit.digit_char <= 7'd75)))
		else $error("digit character out of range");
`endif

endmodule
